### rtl/wsp_pkg.sv
// Shared types and constants for the world-to-screen projection core.
package wsp_pkg;

    typedef logic signed [31:0] t_coef;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PROJ = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SCALE_W-1:0] HEIGHT_RST = 14'd1080;

    // Divider lane depth: magnitude, scale multiply, overflow check,
    // one stage per quotient bit, saturation.
    localparam int QUOT_W  = 32;
    localparam int DIV_LAT = QUOT_W + 4;

endpackage

### rtl/wsp_dot.sv
// Two-stage matrix row products (rows 0, 1 and 3) and their sums.
module wsp_dot #(
    parameter int FRAC_BITS = 16,
    localparam int SW = 66 - FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  wsp_pkg::t_coef        i_mtx [16],
    input  wsp_pkg::t_coef        i_px,
    input  wsp_pkg::t_coef        i_py,
    input  wsp_pkg::t_coef        i_pz,
    output logic signed [SW-1:0]  o_cx,
    output logic signed [SW-1:0]  o_cy,
    output logic signed [SW-1:0]  o_w
);

    wsp_pkg::t_coef      pt [3];
    logic signed [63:0]  r_prod [9];
    wsp_pkg::t_coef      r_tr [3];
    logic signed [SW-1:0] n_sum [3];
    logic signed [SW-1:0] r_sum [3];

    assign pt[0] = i_px;
    assign pt[1] = i_py;
    assign pt[2] = i_pz;

    for (genvar j = 0; j < 3; j++) begin : g_row
        localparam int ROW = (j == 2) ? 3 : j;
        for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[j*3+c] <= i_mtx[ROW*4+c] * pt[c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tr[j] <= i_mtx[ROW*4+3];
            end
        end
        // Each product is floored to FRAC_BITS fractional bits before the sum.
        assign n_sum[j] = SW'(r_prod[j*3+0] >>> FRAC_BITS)
                        + SW'(r_prod[j*3+1] >>> FRAC_BITS)
                        + SW'(r_prod[j*3+2] >>> FRAC_BITS)
                        + SW'(r_tr[j]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sum[j] <= n_sum[j];
            end
        end
    end

    assign o_cx = r_sum[0];
    assign o_cy = r_sum[1];
    assign o_w  = r_sum[2];

endmodule

### rtl/wsp_div.sv
// Pipelined scaled divider lane: num * scale * 2^(F-1) / den, truncated toward zero, saturated.
module wsp_div #(
    parameter int FRAC_BITS = 16,
    localparam int SW = 66 - FRAC_BITS,
    localparam int NW = SW + 1,
    localparam int MW = NW + wsp_pkg::SCALE_W,
    localparam int PW = MW + FRAC_BITS - 1,
    localparam int QW = wsp_pkg::QUOT_W
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [NW-1:0]          i_num,
    input  logic [SW-1:0]                 i_den,
    input  logic [wsp_pkg::SCALE_W-1:0]   i_scale,
    output logic [QW-1:0]                 o_res
);

    logic [NW-1:0]  r_a_mag;
    logic           r_a_neg;
    logic [SW-1:0]  r_a_den;
    logic [MW-1:0]  r_b_prod;
    logic           r_b_neg;
    logic [SW-1:0]  r_b_den;
    logic [PW-1:0]  dividend;

    logic [SW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [SW-1:0]  r_den [QW+1];
    logic           r_ovf [QW+1];
    logic           r_neg [QW+1];
    logic [QW-1:0]  r_res;
    logic [QW-1:0]  q_fin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= i_num[NW-1];
            r_a_mag  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_a_den  <= i_den;
            r_b_prod <= MW'(r_a_mag) * MW'(i_scale);
            r_b_neg  <= r_a_neg;
            r_b_den  <= r_a_den;
        end
    end

    assign dividend = {r_b_prod, {(FRAC_BITS-1){1'b0}}};

    // A quotient of 2^32 or more is flagged here; the remaining bits are then
    // produced one per stage by restoring division.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= SW'(dividend[PW-1:QW]);
            r_low[0] <= dividend[QW-1:0];
            r_q[0]   <= '0;
            r_den[0] <= r_b_den;
            r_ovf[0] <= dividend[PW-1:QW] >= r_b_den;
            r_neg[0] <= r_b_neg;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [SW:0] trial;
        logic        ge;
        assign trial = {r_rem[k], r_low[k][QW-1]};
        assign ge    = trial >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? SW'(trial - {1'b0, r_den[k]}) : SW'(trial);
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign q_fin = r_q[QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QW]) begin
                if (r_ovf[QW] || q_fin > {1'b1, {(QW-1){1'b0}}}) begin
                    r_res <= {1'b1, {(QW-1){1'b0}}};
                end else begin
                    r_res <= QW'(0) - q_fin;
                end
            end else begin
                if (r_ovf[QW] || q_fin[QW-1]) begin
                    r_res <= {1'b0, {(QW-1){1'b1}}};
                end else begin
                    r_res <= q_fin;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

### rtl/world_to_screen_projection_core.sv
// Top level of the world-to-screen perspective projection core.
//
// Input stream: each item is either a coefficient load (tuser = 0) that writes
// one entry of the 4x4 view matrix, or a point projection (tuser = 1). Load
// items give no result; each projection item gives exactly one result item.
// Results carry the visible flag in tuser and screen x and y in tdata, both
// signed fixed point with FRAC_BITS fractional bits; an invisible point gives
// zero coordinates.
// Throughput is one item per cycle while the skid register is empty. A
// projection result passes through an input register, two matrix stages, a
// numerator stage, the 36-stage divider lanes (one quotient bit per stage)
// and the output register.
// The whole pipeline advances together. When the receiver stalls, the output
// register holds its item and a one-item skid register takes the next; only
// when the skid register is full does the input stop being ready, so no item
// is lost or repeated.
// Reset (synchronous, active low) clears the matrix to zero, sets the viewport
// to 1920 x 1080 and empties the pipeline. Viewport writes through the
// configuration port take effect at once and are meant for an idle block.
module world_to_screen_projection_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
    // point_z[131:100], zero fill [135:132]
    input  logic [135:0]                  i_s_axis_tdata,
    // op[0]
    input  logic [0:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // screen_x[31:0], screen_y[63:32]
    output logic [63:0]                   o_m_axis_tdata,
    // visible[0]
    output logic [0:0]                    o_m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [wsp_pkg::SCALE_W-1:0]   i_cfg_data
);

    localparam int SW  = 66 - FRAC_BITS;
    localparam int NW  = SW + 1;
    localparam int LAT = 3 + wsp_pkg::DIV_LAT;
    localparam logic signed [SW-1:0] W_MIN = SW'(((1 << FRAC_BITS) + 999) / 1000);

    logic                          en;
    logic                          accept;
    logic                          take;

    logic [wsp_pkg::SCALE_W-1:0]   r_width;
    logic [wsp_pkg::SCALE_W-1:0]   r_height;
    wsp_pkg::t_coef                r_mtx [16];

    logic                          r_s0_v;
    logic                          r_s0_op;
    logic [3:0]                    r_s0_idx;
    wsp_pkg::t_coef                r_s0_val;
    wsp_pkg::t_coef                r_s0_x;
    wsp_pkg::t_coef                r_s0_y;
    wsp_pkg::t_coef                r_s0_z;

    logic                          r_vld [LAT];
    logic                          r_vis [wsp_pkg::DIV_LAT+1];

    logic signed [SW-1:0]          cx;
    logic signed [SW-1:0]          cy;
    logic signed [SW-1:0]          w;
    logic signed [NW-1:0]          r_nx;
    logic signed [NW-1:0]          r_ny;
    logic [SW-1:0]                 r_w;
    logic [31:0]                   res_x;
    logic [31:0]                   res_y;

    logic                          fin_v;
    logic                          fin_vis;
    logic [63:0]                   fin_data;

    logic                          r_out_v;
    logic                          r_out_vis;
    logic [63:0]                   r_out_data;
    logic                          r_skid_v;
    logic                          r_skid_vis;
    logic [63:0]                   r_skid_data;

    // The pipeline moves whenever the skid register is free.
    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;
    assign take            = r_out_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsp_pkg::WIDTH_RST;
            r_height <= wsp_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wsp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                wsp_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_op  <= i_s_axis_tuser[0];
            r_s0_idx <= i_s_axis_tdata[3:0];
            r_s0_val <= i_s_axis_tdata[35:4];
            r_s0_x   <= i_s_axis_tdata[67:36];
            r_s0_y   <= i_s_axis_tdata[99:68];
            r_s0_z   <= i_s_axis_tdata[131:100];
        end
    end

    // A load writes the matrix as it leaves the input register. A projection
    // ahead of it read the matrix as it left the input register, before the
    // write, and one behind it reads the new value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mtx[i] <= '0;
            end
        end else if (en && r_s0_v && r_s0_op == wsp_pkg::OP_LOAD) begin
            r_mtx[r_s0_idx] <= r_s0_val;
        end
    end

    wsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mtx (r_mtx),
        .i_px  (r_s0_x),
        .i_py  (r_s0_y),
        .i_pz  (r_s0_z),
        .o_cx  (cx),
        .o_cy  (cy),
        .o_w   (w)
    );

    // Numerators for both axes and the visibility test.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx     <= NW'(cx) + NW'(w);
            r_ny     <= NW'(w) - NW'(cy);
            r_w      <= $unsigned(w);
            r_vis[0] <= w >= W_MIN;
        end
    end

    for (genvar k = 1; k <= wsp_pkg::DIV_LAT; k++) begin : g_vis
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_vis[k] <= r_vis[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_s0_v && r_s0_op == wsp_pkg::OP_PROJ;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_nx),
        .i_den   (r_w),
        .i_scale (r_width),
        .o_res   (res_x)
    );

    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_ny),
        .i_den   (r_w),
        .i_scale (r_height),
        .o_res   (res_y)
    );

    assign fin_v    = r_vld[LAT-1];
    assign fin_vis  = r_vis[wsp_pkg::DIV_LAT];
    assign fin_data = fin_vis ? {res_y, res_x} : 64'd0;

    // Output register with a one-item skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (fin_v) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out_vis  <= r_skid_vis;
                r_out_data <= r_skid_data;
            end
        end else if (fin_v) begin
            if (!r_out_v || take) begin
                r_out_vis  <= fin_vis;
                r_out_data <= fin_data;
            end else begin
                r_skid_vis  <= fin_vis;
                r_skid_data <= fin_data;
            end
        end
    end

    assign o_m_axis_tvalid   = r_out_v;
    assign o_m_axis_tuser[0] = r_out_vis;
    assign o_m_axis_tdata    = r_out_data;

`ifndef SYNTHESIS
    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 64'd0)
        else $error("invisible result carries nonzero coordinates");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r_skid_v)
        else $error("output not empty after reset");
`endif

endmodule

### bench/world_to_screen_projection_core_tb.sv
// Self-checking testbench for the world-to-screen projection core.
`timescale 1ns / 1ps

module world_to_screen_projection_core_tb;

    localparam int FRAC       = 16;
    localparam int PIPE_DEPTH = 40;
    localparam int DRAIN_WAIT = PIPE_DEPTH + 8;
    localparam int STALL_MAX  = 6000;
    // Smallest raw w that still counts as visible: ceil(2^FRAC / 1000).
    localparam longint W_FLOOR = ((longint'(1) << FRAC) + 999) / 1000;
    localparam wsp_pkg::t_coef ONE = 32'sh0001_0000;

    typedef struct {
        logic           op;
        logic [3:0]     idx;
        wsp_pkg::t_coef coef;
        wsp_pkg::t_coef px;
        wsp_pkg::t_coef py;
        wsp_pkg::t_coef pz;
    } t_item;

    typedef struct {
        logic           vis;
        wsp_pkg::t_coef sx;
        wsp_pkg::t_coef sy;
    } t_pixel;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_valid;
    logic                        s_ready;
    logic [135:0]                s_data;
    logic [0:0]                  s_user;
    logic                        m_valid;
    logic                        m_ready;
    logic [63:0]                 m_data;
    logic [0:0]                  m_user;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [wsp_pkg::SCALE_W-1:0] cfg_data;

    world_to_screen_projection_core #(.FRAC_BITS(FRAC)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Shadow copy of the block's state: the matrix follows accepted items, the viewport its writes.
    wsp_pkg::t_coef              view_matrix [16];
    logic [wsp_pkg::SCALE_W-1:0] view_width;
    logic [wsp_pkg::SCALE_W-1:0] view_height;

    t_item  pending_items [$];
    t_pixel expected_pixels [$];
    t_item  cur_item;
    int     mismatch_count = 0;
    bit     quiet = 1'b0;
    int     stall_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // One matrix row times (x, y, z, 1); each product floors to FRAC bits.
    function automatic longint row_times_point(int r, t_item it);
        longint acc;
        acc = (longint'(view_matrix[r*4+0]) * longint'(it.px)) >>> FRAC;
        acc += (longint'(view_matrix[r*4+1]) * longint'(it.py)) >>> FRAC;
        acc += (longint'(view_matrix[r*4+2]) * longint'(it.pz)) >>> FRAC;
        acc += longint'(view_matrix[r*4+3]);
        return acc;
    endfunction

    // trunc(num * scale / (2w)) in FRAC fractional bits, saturated to 32 bits.
    function automatic wsp_pkg::t_coef pixel_scale(longint num,
                                                   logic [wsp_pkg::SCALE_W-1:0] scale,
                                                   longint w);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] quot;
        neg  = num < 0;
        mag  = neg ? 64'(-num) : 64'(num);
        quot = (128'(mag) * (128'(scale) << (FRAC - 1))) / 128'(w);
        if (neg)
            return (quot > 128'h8000_0000) ? 32'sh8000_0000
                                           : wsp_pkg::t_coef'(-quot[31:0]);
        return (quot > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : wsp_pkg::t_coef'(quot[31:0]);
    endfunction

    // Applies one accepted item to the shadow state and, for a projection, queues its result.
    function automatic void predict_item(t_item it);
        longint w, cx, cy;
        t_pixel px;
        if (it.op == wsp_pkg::OP_LOAD) begin
            view_matrix[it.idx] = it.coef;
            return;
        end
        w  = row_times_point(3, it);
        px = '{1'b0, 32'sd0, 32'sd0};
        if (w >= W_FLOOR) begin
            cx = row_times_point(0, it);
            cy = row_times_point(1, it);
            px.vis = 1'b1;
            px.sx  = pixel_scale(cx + w, view_width, w);
            px.sy  = pixel_scale(w - cy, view_height, w);
        end
        expected_pixels.push_back(px);
    endfunction

    // Driver: pops pending items and presents them, with random idle bursts.
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic  next_valid;
        t_item it;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            s_user  <= '0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                predict_item(cur_item);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    if (!quiet && $urandom_range(9) == 0) begin
                        send_gap = $urandom_range(19, 1);
                    end else begin
                        it = pending_items.pop_front();
                        cur_item = it;
                        s_data <= {4'd0, it.pz, it.py, it.px, it.coef, it.idx};
                        s_user <= it.op;
                        next_valid = 1'b1;
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: checks every result against the oldest expectation.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_user[0] !== want.vis)
                        report_mismatch("visible", 32'(m_user[0]), 32'(want.vis));
                    if (m_data[31:0] !== want.sx)
                        report_mismatch("screen_x", m_data[31:0], want.sx);
                    if (m_data[63:32] !== want.sy)
                        report_mismatch("screen_y", m_data[63:32], want.sy);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(11) == 0) begin
                recv_gap = $urandom_range(18, 0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("world_to_screen_projection_core_tb: FAIL");
            $finish;
        end
    end

    function automatic t_item load_item(int idx, wsp_pkg::t_coef val);
        t_item it;
        it = '{wsp_pkg::OP_LOAD, 4'(idx), val, wsp_pkg::t_coef'($urandom),
               wsp_pkg::t_coef'($urandom), wsp_pkg::t_coef'($urandom)};
        return it;
    endfunction

    function automatic t_item point_item(wsp_pkg::t_coef x, wsp_pkg::t_coef y,
                                         wsp_pkg::t_coef z);
        t_item it;
        it = '{wsp_pkg::OP_PROJ, 4'($urandom), wsp_pkg::t_coef'($urandom), x, y, z};
        return it;
    endfunction

    function automatic wsp_pkg::t_coef sane_coef();
        return wsp_pkg::t_coef'(int'($urandom_range(262144)) - 131072);
    endfunction

    // Loads a perspective-like camera: w follows z plus small terms.
    task automatic queue_camera();
        for (int i = 0; i < 16; i++) begin
            if (i == 14)
                pending_items.push_back(load_item(i, ONE + (sane_coef() >>> 3)));
            else if (i >= 12)
                pending_items.push_back(load_item(i, sane_coef() >>> 4));
            else
                pending_items.push_back(load_item(i, sane_coef()));
        end
    endtask

    // Mostly well-formed points with a sane camera; some raw noise.
    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 4)
                pending_items.push_back(load_item($urandom_range(15), sane_coef()));
            else if (r < 8)
                pending_items.push_back(load_item($urandom_range(15),
                                                  wsp_pkg::t_coef'($urandom)));
            else if (r < 16)
                pending_items.push_back(point_item(wsp_pkg::t_coef'($urandom),
                                                   wsp_pkg::t_coef'($urandom),
                                                   wsp_pkg::t_coef'($urandom)));
            else
                pending_items.push_back(point_item(
                    wsp_pkg::t_coef'(int'($urandom_range(13107200)) - 6553600),
                    wsp_pkg::t_coef'(int'($urandom_range(13107200)) - 6553600),
                    wsp_pkg::t_coef'($urandom_range(65536000, 1))));
        end
    endtask

    task automatic write_viewport(logic idx, logic [wsp_pkg::SCALE_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == wsp_pkg::CFG_WIDTH)
            view_width = val;
        else
            view_height = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits for the pipeline to drain, including trailing loads. The check runs
    // at the falling edge, after the driver's updates for the cycle have settled.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic [wsp_pkg::SCALE_W-1:0] widths  [6];
        logic [wsp_pkg::SCALE_W-1:0] heights [6];
        widths  = '{wsp_pkg::WIDTH_RST, 14'd0, 14'd1, 14'd8192, 14'd16383, 14'd0};
        heights = '{wsp_pkg::HEIGHT_RST, 14'd16383, 14'd1, 14'd8192, 14'd0, 14'd0};
        widths[5]  = 14'($urandom);
        heights[5] = 14'($urandom);
        foreach (view_matrix[i]) view_matrix[i] = '0;
        view_width  = wsp_pkg::WIDTH_RST;
        view_height = wsp_pkg::HEIGHT_RST;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = wsp_pkg::CFG_WIDTH;
        cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the cleared matrix gives w = 0, so the point is hidden.
        pending_items.push_back(point_item(ONE, ONE, ONE));
        // Identity camera with w = z to probe the visibility threshold.
        for (int i = 0; i < 16; i++)
            pending_items.push_back(load_item(i, (i == 0 || i == 5 || i == 14) ? ONE : 0));
        pending_items.push_back(point_item(0, 0, wsp_pkg::t_coef'(W_FLOOR - 1)));
        pending_items.push_back(point_item(0, 0, wsp_pkg::t_coef'(W_FLOOR)));
        pending_items.push_back(point_item(0, 0, -ONE));
        pending_items.push_back(point_item(ONE, -ONE, ONE));
        // Tiny w with extreme x and y drives both coordinates into saturation.
        pending_items.push_back(point_item(32'sh7FFF_FFFF, 32'sh8000_0000,
                                           wsp_pkg::t_coef'(W_FLOOR)));
        pending_items.push_back(point_item(32'sh8000_0000, 32'sh7FFF_FFFF,
                                           wsp_pkg::t_coef'(W_FLOOR)));
        pending_items.push_back(point_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        // Extreme coefficients meet extreme points.
        pending_items.push_back(load_item(0, 32'sh8000_0000));
        pending_items.push_back(load_item(1, 32'sh7FFF_FFFF));
        pending_items.push_back(point_item(32'sh8000_0000, 32'sh8000_0000, ONE));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_viewport(wsp_pkg::CFG_WIDTH, widths[ph]);
                write_viewport(wsp_pkg::CFG_HEIGHT, heights[ph]);
            end
            quiet = (ph == 5);
            queue_camera();
            queue_random(240);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("world_to_screen_projection_core_tb: PASS");
        end else begin
            $display("world_to_screen_projection_core_tb: FAIL");
        end
        $finish;
    end

endmodule

### world_to_screen_projection_core.f
rtl/wsp_pkg.sv
rtl/wsp_dot.sv
rtl/wsp_div.sv
rtl/world_to_screen_projection_core.sv
bench/world_to_screen_projection_core_tb.sv
